### sv/pp_pkg.sv
`timescale 1ns / 1ps

package pp_pkg;

    localparam int MAX_TERMS   = 16;

    localparam int COEFF_IN_W  = 16;
    localparam int COEFF_OUT_W = 36;
    localparam int DEGREE_W    = 5;

    // store index, store fill count, product degree index
    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int K_W   = $clog2(2 * MAX_TERMS - 1);

    localparam int PROD_W = 2 * COEFF_IN_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TERMS);
    localparam int WIDE_W = (ACC_W > COEFF_OUT_W) ? ACC_W : COEFF_OUT_W;

    localparam logic signed [WIDE_W-1:0] SAT_MAX =
        {{(WIDE_W - COEFF_OUT_W + 1){1'b0}}, {(COEFF_OUT_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_MIN =
        {{(WIDE_W - COEFF_OUT_W + 1){1'b1}}, {(COEFF_OUT_W - 1){1'b0}}};

    localparam logic KIND_FIRST  = 1'b0;
    localparam logic KIND_SECOND = 1'b1;

    typedef struct packed {
        logic                          kind;
        logic signed [COEFF_IN_W-1:0]  coeff_in;
        logic                          end_of_poly;
    } coeff_t;

    typedef struct packed {
        logic signed [COEFF_OUT_W-1:0] coeff_out;
        logic [DEGREE_W-1:0]           degree;
        logic                          final_res;
        logic                          truncated;
    } prod_t;

endpackage

### sv/polynomial_product.sv
`timescale 1ns / 1ps

// channel | direction | valid       | stall       | payload
// coeff   | in        | coeff_valid | coeff_stall | coeff (pp_pkg::coeff_t)
// prod    | out       | prod_valid  | prod_stall  | prod  (pp_pkg::prod_t)
//
// Loading stores one coefficient per cycle into two 16-entry synchronous RAMs.
// After the closing coefficient, product coefficient k passes through setup,
// one RAM read pair per term, a pipeline drain and the output state.
// coeff_stall stays high from the closing transaction until the last product
// transaction; a stalled output holds the sequencer.
// Reset clears counts, flags and control; RAM contents are not reset.

module polynomial_product (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            coeff_valid,
    output logic            coeff_stall,
    input  pp_pkg::coeff_t  coeff,
    output logic            prod_valid,
    input  logic            prod_stall,
    output pp_pkg::prod_t   prod
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [pp_pkg::CNT_W-1:0] first_cnt_reg, first_cnt_next;
    logic [pp_pkg::CNT_W-1:0] second_cnt_reg, second_cnt_next;
    logic                     ovf_reg, ovf_next;

    logic [pp_pkg::CNT_W-1:0] n1_reg, n1_next;
    logic [pp_pkg::CNT_W-1:0] n2_reg, n2_next;
    logic                     zero_first_reg, zero_first_next;
    logic                     trunc_reg, trunc_next;
    logic [pp_pkg::K_W-1:0]   k_reg, k_next;
    logic [pp_pkg::K_W-1:0]   k_last_reg, k_last_next;
    logic [pp_pkg::IDX_W-1:0] i_reg, i_next;
    logic [pp_pkg::IDX_W-1:0] i_hi_reg, i_hi_next;

    logic s1_reg, s2_reg;

    logic signed [pp_pkg::COEFF_IN_W-1:0] mem_a [pp_pkg::MAX_TERMS];
    logic signed [pp_pkg::COEFF_IN_W-1:0] mem_b [pp_pkg::MAX_TERMS];
    logic signed [pp_pkg::COEFF_IN_W-1:0] rd_a_reg, rd_b_reg;

    logic signed [pp_pkg::COEFF_IN_W-1:0] op_a;
    logic signed [pp_pkg::PROD_W-1:0]     prod_reg;
    logic signed [pp_pkg::ACC_W-1:0]      acc_reg;
    logic signed [pp_pkg::WIDE_W-1:0]     acc_wide;
    logic signed [pp_pkg::COEFF_OUT_W-1:0] sat_val;

    logic                     out_valid_reg;
    pp_pkg::prod_t            out_reg;

    logic                     accept;
    logic                     out_take;
    logic                     wr_a, wr_b;
    logic                     first_full, second_full;
    logic [pp_pkg::IDX_W-1:0] rd_addr_a, rd_addr_b;
    logic [pp_pkg::CNT_W-1:0] n2_close;
    logic [pp_pkg::CNT_W-1:0] n1_close;
    logic [pp_pkg::K_W:0]     k_ext, n2_ext, n1m1, lo, hi;

    assign coeff_stall = (state_reg != ST_LOAD);
    assign accept      = coeff_valid && !coeff_stall;
    assign prod_valid  = out_valid_reg;
    assign prod        = out_reg;
    assign out_take    = out_valid_reg && !prod_stall;

    assign first_full  = (first_cnt_reg >= pp_pkg::CNT_W'(pp_pkg::MAX_TERMS));
    assign second_full = (second_cnt_reg >= pp_pkg::CNT_W'(pp_pkg::MAX_TERMS));
    assign wr_a = accept && (coeff.kind == pp_pkg::KIND_FIRST) && !first_full;
    assign wr_b = accept && (coeff.kind == pp_pkg::KIND_SECOND) && !second_full;

    // term range of degree k: max(0, k-n2+1) .. min(k, n1-1)
    assign k_ext  = {1'b0, k_reg};
    assign n2_ext = (pp_pkg::K_W + 1)'(n2_reg);
    assign n1m1   = (pp_pkg::K_W + 1)'(n1_reg) - 1'b1;
    assign lo     = (k_ext >= n2_ext) ? (k_ext - n2_ext + 1'b1) : '0;
    assign hi     = (k_ext < n1m1) ? k_ext : n1m1;

    assign rd_addr_a = i_reg;
    assign rd_addr_b = pp_pkg::IDX_W'(k_reg - pp_pkg::K_W'(i_reg));

    assign n2_close = second_full ? second_cnt_reg : second_cnt_reg + 1'b1;
    assign n1_close = (first_cnt_reg == '0) ? pp_pkg::CNT_W'(1) : first_cnt_reg;

    // an empty first list stands for the single coefficient zero
    assign op_a = zero_first_reg ? '0 : rd_a_reg;

    assign acc_wide = pp_pkg::WIDE_W'(acc_reg);
    always_comb
    begin
        if (acc_wide > pp_pkg::SAT_MAX)
            sat_val = pp_pkg::COEFF_OUT_W'(pp_pkg::SAT_MAX);
        else if (acc_wide < pp_pkg::SAT_MIN)
            sat_val = pp_pkg::COEFF_OUT_W'(pp_pkg::SAT_MIN);
        else
            sat_val = pp_pkg::COEFF_OUT_W'(acc_wide);
    end

    // coefficient stores; the closing write lands before the first read
    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[first_cnt_reg[pp_pkg::IDX_W-1:0]] <= coeff.coeff_in;
        if (wr_b)
            mem_b[second_cnt_reg[pp_pkg::IDX_W-1:0]] <= coeff.coeff_in;
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    always_comb
    begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        ovf_next        = ovf_reg;
        n1_next         = n1_reg;
        n2_next         = n2_reg;
        zero_first_next = zero_first_reg;
        trunc_next      = trunc_reg;
        k_next          = k_reg;
        k_last_next     = k_last_reg;
        i_next          = i_reg;
        i_hi_next       = i_hi_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (coeff.kind == pp_pkg::KIND_FIRST)
                    begin
                        if (first_full)
                            ovf_next = 1'b1;
                        else
                            first_cnt_next = first_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        if (second_full)
                            ovf_next = 1'b1;
                        else
                            second_cnt_next = second_cnt_reg + 1'b1;
                        if (coeff.end_of_poly)
                        begin
                            n1_next         = n1_close;
                            n2_next         = n2_close;
                            zero_first_next = (first_cnt_reg == '0);
                            trunc_next      = ovf_reg || second_full;
                            k_next          = '0;
                            k_last_next     = pp_pkg::K_W'(
                                (pp_pkg::CNT_W + 1)'(n1_close)
                                + (pp_pkg::CNT_W + 1)'(n2_close) - 2'd2);
                            state_next      = ST_SETUP;
                        end
                    end
                end
            end
            ST_SETUP:
            begin
                i_next     = pp_pkg::IDX_W'(lo);
                i_hi_next  = pp_pkg::IDX_W'(hi);
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (i_reg == i_hi_reg)
                    state_next = ST_DRAIN;
                else
                    i_next = i_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (!s1_reg && !s2_reg)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_take)
                begin
                    if (k_reg == k_last_reg)
                    begin
                        first_cnt_next  = '0;
                        second_cnt_next = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            s1_reg         <= 1'b0;
            s2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            ovf_reg        <= ovf_next;
            s1_reg         <= (state_reg == ST_RUN);
            s2_reg         <= s1_reg;
            if (state_reg == ST_DRAIN && !s1_reg && !s2_reg)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg         <= n1_next;
        n2_reg         <= n2_next;
        zero_first_reg <= zero_first_next;
        trunc_reg      <= trunc_next;
        k_reg          <= k_next;
        k_last_reg     <= k_last_next;
        i_reg          <= i_next;
        i_hi_reg       <= i_hi_next;

        prod_reg <= op_a * rd_b_reg;

        // clear on each new degree, then add every product that arrives
        if (state_reg == ST_SETUP)
            acc_reg <= '0;
        else if (s2_reg)
            acc_reg <= acc_reg + pp_pkg::ACC_W'(prod_reg);

        if (state_reg == ST_DRAIN && !s1_reg && !s2_reg)
        begin
            out_reg.coeff_out <= sat_val;
            out_reg.degree    <= pp_pkg::DEGREE_W'(k_reg);
            out_reg.final_res <= (k_reg == k_last_reg);
            out_reg.truncated <= trunc_reg;
        end
    end

endmodule
